// ===== rtl/core/mcc_pkg.sv =====
package mcc_pkg;

	localparam int MAX_BANDS   = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int COV_W       = 48;
	localparam int FRAC_BITS   = 8;

	localparam int COUNT_W   = $clog2(MAX_BANDS + 1);
	localparam int SUM_W     = SAMPLE_BITS + COUNT_W;
	localparam int PROD_W    = 2 * SAMPLE_BITS;
	localparam int SUMP_W    = PROD_W + COUNT_W - 1;
	localparam int NUM_W     = SUMP_W + COUNT_W + 2;
	localparam int DEN_W     = 2 * COUNT_W;
	localparam int DIVD_W    = NUM_W + FRAC_BITS + 1;
	localparam int DIV_CNT_W = $clog2(DIVD_W);

	localparam logic [DIVD_W-1:0] Q_POS_LIM = {{(DIVD_W - COV_W + 1){1'b0}}, {(COV_W - 1){1'b1}}};
	localparam logic [DIVD_W-1:0] Q_NEG_LIM = Q_POS_LIM + DIVD_W'(1);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_a;
		logic signed [SAMPLE_BITS-1:0] sample_b;
		logic                          a_defined;
		logic                          b_defined;
		logic                          column_end;
	} in_item_t;

	typedef struct packed {
		logic signed [COV_W-1:0] covariance;
		logic                    result_undefined;
		logic [COUNT_W-1:0]      pairs_used;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_TERMS,
		ST_NUM,
		ST_ABS,
		ST_PREP,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic accumulate;
		logic terms;
		logic diff;
		logic magnitude;
		logic prep;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic col_end;
		logic div_last;
	} status_t;

endpackage

// ===== rtl/core/masked_column_covariance_unit.sv =====
// Sample covariance of one pixel column, fed one band pair per item. A pair
// counts only when both samples are defined; at most MAX_BANDS pairs count per
// column. The item flagged column_end closes the column and produces one result:
// (n*Sxy - Sx*Sy)/(n*(n-1)) in signed fixed point with 8 fraction bits, rounded
// to nearest with ties away from zero, or zero with result_undefined set when
// fewer than two pairs counted. Each band item is captured with its sample product
// and then accumulated. A column-end item then passes the terms, numerator and
// magnitude steps and the divider preparation, then a restoring divider that
// retires one quotient bit per cycle over 60 bits. A new item is taken while the
// previous result waits in the output register.
module masked_column_covariance_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  mcc_pkg::in_item_t  sample,
	output logic               result_valid,
	input  logic               result_stall,
	output mcc_pkg::out_item_t result
);

	mcc_pkg::cmd_t    cmd;
	mcc_pkg::status_t status;

	mcc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	mcc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (sample),
		.status (status),
		.result (result)
	);

endmodule

// ===== rtl/core/mcc_ctrl.sv =====
module mcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	output logic              result_valid,
	input  logic              result_stall,
	input  mcc_pkg::status_t  status,
	output mcc_pkg::cmd_t     cmd
);

	mcc_pkg::state_t state_q, state_d;
	logic            result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mcc_pkg::ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		sample_stall = 1'b1;
		case (state_q)
			mcc_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.capture = 1'b1;
					state_d     = mcc_pkg::ST_ACC;
				end
			end
			mcc_pkg::ST_ACC: begin
				cmd.accumulate = 1'b1;
				state_d        = status.col_end ? mcc_pkg::ST_TERMS : mcc_pkg::ST_IDLE;
			end
			mcc_pkg::ST_TERMS: begin
				cmd.terms = 1'b1;
				state_d   = mcc_pkg::ST_NUM;
			end
			mcc_pkg::ST_NUM: begin
				cmd.diff = 1'b1;
				state_d  = mcc_pkg::ST_ABS;
			end
			mcc_pkg::ST_ABS: begin
				cmd.magnitude = 1'b1;
				state_d       = mcc_pkg::ST_PREP;
			end
			mcc_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = mcc_pkg::ST_DIV;
			end
			mcc_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = mcc_pkg::ST_OUT;
				end
			end
			mcc_pkg::ST_OUT: begin
				if (!result_valid_q || !result_stall) begin
					cmd.load_out = 1'b1;
					state_d      = mcc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mcc_pkg::ST_IDLE;
			end
		endcase
	end

	assign result_valid = result_valid_q;

endmodule

// ===== rtl/core/mcc_dp.sv =====
module mcc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  mcc_pkg::cmd_t      cmd,
	input  mcc_pkg::in_item_t  sample,
	output mcc_pkg::status_t   status,
	output mcc_pkg::out_item_t result
);

	logic signed [mcc_pkg::SAMPLE_BITS-1:0] a_q, b_q;
	logic signed [mcc_pkg::PROD_W-1:0]      prod_s1;
	logic                                   use_q, end_q;

	logic [mcc_pkg::COUNT_W-1:0]     cnt_q;
	logic signed [mcc_pkg::SUM_W-1:0]  sx_q, sy_q;
	logic signed [mcc_pkg::SUMP_W-1:0] sxy_q;

	logic signed [mcc_pkg::NUM_W-1:0] t1_q, t2_q, num_q;
	logic [mcc_pkg::DEN_W-1:0]        den_q;
	logic [mcc_pkg::NUM_W-1:0]        mag_q;
	logic                             neg_q;

	logic [mcc_pkg::DIVD_W-1:0]    divd_q;
	logic [mcc_pkg::DEN_W-1:0]     rem_q;
	logic [mcc_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [mcc_pkg::DEN_W:0]       trial;
	logic                          qbit;

	logic                           undef;
	logic signed [mcc_pkg::COV_W-1:0] cov_sat;
	mcc_pkg::out_item_t             result_q;

	// input capture and product
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			a_q     <= sample.sample_a;
			b_q     <= sample.sample_b;
			prod_s1 <= mcc_pkg::PROD_W'(sample.sample_a) * mcc_pkg::PROD_W'(sample.sample_b);
			use_q   <= sample.a_defined & sample.b_defined;
			end_q   <= sample.column_end;
		end
	end

	// running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
		end else if (cmd.load_out) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
		end else if (cmd.accumulate && use_q
				&& cnt_q < mcc_pkg::COUNT_W'(mcc_pkg::MAX_BANDS)) begin
			cnt_q <= cnt_q + mcc_pkg::COUNT_W'(1);
			sx_q  <= sx_q + mcc_pkg::SUM_W'(a_q);
			sy_q  <= sy_q + mcc_pkg::SUM_W'(b_q);
			sxy_q <= sxy_q + mcc_pkg::SUMP_W'(prod_s1);
		end
	end

	// numerator, denominator and restoring divider
	assign trial = {rem_q, divd_q[mcc_pkg::DIVD_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.terms) begin
			t1_q  <= mcc_pkg::NUM_W'($signed({1'b0, cnt_q})) * mcc_pkg::NUM_W'(sxy_q);
			t2_q  <= mcc_pkg::NUM_W'(sx_q) * mcc_pkg::NUM_W'(sy_q);
			den_q <= mcc_pkg::DEN_W'(cnt_q)
				* mcc_pkg::DEN_W'(cnt_q - mcc_pkg::COUNT_W'(1));
		end
		if (cmd.diff) begin
			num_q <= t1_q - t2_q;
		end
		if (cmd.magnitude) begin
			neg_q <= num_q[mcc_pkg::NUM_W-1];
			mag_q <= num_q[mcc_pkg::NUM_W-1] ? mcc_pkg::NUM_W'(-num_q) : mcc_pkg::NUM_W'(num_q);
		end
		if (cmd.prep) begin
			divd_q    <= mcc_pkg::DIVD_W'({mag_q, {mcc_pkg::FRAC_BITS{1'b0}}})
				+ mcc_pkg::DIVD_W'(den_q >> 1);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= qbit ? mcc_pkg::DEN_W'(trial - {1'b0, den_q})
				: mcc_pkg::DEN_W'(trial);
			divd_q    <= {divd_q[mcc_pkg::DIVD_W-2:0], qbit};
			div_cnt_q <= div_cnt_q + mcc_pkg::DIV_CNT_W'(1);
		end
	end

	// rounding already folded in; saturate to the output range
	assign undef = (cnt_q < mcc_pkg::COUNT_W'(2));

	always_comb begin
		if (neg_q) begin
			if (divd_q > mcc_pkg::Q_NEG_LIM) begin
				cov_sat = {1'b1, {(mcc_pkg::COV_W-1){1'b0}}};
			end else begin
				cov_sat = mcc_pkg::COV_W'(-divd_q);
			end
		end else begin
			if (divd_q > mcc_pkg::Q_POS_LIM) begin
				cov_sat = {1'b0, {(mcc_pkg::COV_W-1){1'b1}}};
			end else begin
				cov_sat = mcc_pkg::COV_W'(divd_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.covariance       <= undef ? '0 : cov_sat;
			result_q.result_undefined <= undef;
			result_q.pairs_used       <= cnt_q;
		end
	end

	assign status.col_end  = end_q;
	assign status.div_last = (div_cnt_q == mcc_pkg::DIV_CNT_W'(mcc_pkg::DIVD_W - 1));
	assign result          = result_q;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mcc_pkg::*;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t res;
	} band_row_t;

	localparam int DIR_ROWS = 19;
	localparam int RAND_ITEMS = 1950;
	localparam int CALM_TAIL = 150;
	localparam longint COV_MAX = (longint'(1) <<< (COV_W - 1)) - 1;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      sample_valid = 1'b0;
	logic      sample_stall;
	in_item_t  sample = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	masked_column_covariance_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #5 clk = ~clk;

	// directed columns: item {a, b, a_def, b_def, end}, typed flag, result {cov, undef, pairs}
	band_row_t directed_rows [DIR_ROWS] = '{
		'{'{0, 0, 1'b0, 1'b0, 1'b1}, 1'b1, '{0, 1'b1, 0}},
		'{'{5, 7, 1'b1, 1'b1, 1'b1}, 1'b1, '{0, 1'b1, 1}},
		'{'{32767, -32768, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{-32768, 32767, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{32767, 32767, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{-32768, -32768, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{1, 2, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{2, 4, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{3, 6, 1'b1, 1'b1, 1'b1}, 1'b1, '{512, 1'b0, 3}},
		'{'{32767, -32768, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{-32768, 32767, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{100, -100, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{100, -100, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{100, -100, 1'b1, 1'b1, 1'b1}, 1'b1, '{0, 1'b0, 3}},
		'{'{0, 0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{0, 0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{1, 1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{9, 9, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{-1, -1, 1'b1, 1'b0, 1'b1}, 1'b1, '{0, 1'b1, 1}}
	};

	band_row_t stim_q [$];
	out_item_t cov_expect_q [$];

	int unsigned band_pairs;
	longint      acc_a, acc_b, acc_ab;

	int        total_items;
	int        sent;
	int        mismatches;
	int        gap_left;
	int        hold_left;
	bit        cur_typed;
	out_item_t cur_res;
	out_item_t want;

	function automatic void band_fold(input in_item_t s, output bit done, output out_item_t r);
		longint            a, b, n, num, cov;
		longint unsigned   mag, den, q;
		bit                neg;
		a = longint'($signed(s.sample_a));
		b = longint'($signed(s.sample_b));
		done = 1'b0;
		r = '0;
		if (s.a_defined && s.b_defined && band_pairs < MAX_BANDS) begin
			band_pairs++;
			acc_a += a;
			acc_b += b;
			acc_ab += a * b;
		end
		if (s.column_end) begin
			done = 1'b1;
			r.pairs_used = band_pairs[COUNT_W-1:0];
			r.result_undefined = 1'b1;
			if (band_pairs >= 2) begin
				n = longint'(band_pairs);
				num = n * acc_ab - acc_a * acc_b;
				neg = num < 0;
				mag = neg ? longint'(-num) : num;
				mag = mag << FRAC_BITS;
				den = n * (n - 1);
				q = (mag + den / 2) / den;
				if (neg)
					cov = (q > COV_MAX + 1) ? -COV_MAX - 1 : -longint'(q);
				else
					cov = (q > COV_MAX) ? COV_MAX : longint'(q);
				r.covariance = cov[COV_W-1:0];
				r.result_undefined = 1'b0;
			end
			band_pairs = 0;
			acc_a = 0;
			acc_b = 0;
			acc_ab = 0;
		end
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 11))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic bit calm();
		return (sent + CALM_TAIL >= total_items) || ((sent / 120) % 4 == 3);
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		bit        took, has_res, nxt_valid;
		out_item_t res;
		band_row_t row;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			gap_left = 0;
		end else begin
			took = sample_valid && !sample_stall;
			if (took) begin
				band_fold(sample, has_res, res);
				if (has_res)
					cov_expect_q.insert(cov_expect_q.size(), cur_typed ? cur_res : res);
				sent++;
			end
			if (!sample_valid || took) begin
				nxt_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (!calm() && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 3);
				end else if (stim_q.size() > 0) begin
					row = stim_q.pop_front();
					sample <= row.item;
					cur_typed = row.typed;
					cur_res = row.res;
					nxt_valid = 1'b1;
				end
				sample_valid <= nxt_valid;
			end
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (!calm() && $urandom_range(0, 5) == 0) begin
			hold_left = $urandom_range(0, 3);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (cov_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: cov %0d undef %0d pairs %0d",
						$signed(result.covariance), result.result_undefined,
						result.pairs_used);
			end else begin
				want = cov_expect_q.pop_front();
				if (result.covariance !== want.covariance
						|| result.result_undefined !== want.result_undefined
						|| result.pairs_used !== want.pairs_used) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected cov %0d undef %0d pairs %0d,",
							$signed(want.covariance), want.result_undefined,
							want.pairs_used,
							" got cov %0d undef %0d pairs %0d",
							$signed(result.covariance), result.result_undefined,
							result.pairs_used);
				end
			end
		end
	end

	initial begin
		int        len, kind, long_cols, made;
		in_item_t  it;
		band_row_t row;
		band_pairs = 0;
		acc_a = 0;
		acc_b = 0;
		acc_ab = 0;
		sent = 0;
		mismatches = 0;
		long_cols = 0;
		foreach (directed_rows[i])
			stim_q.insert(stim_q.size(), directed_rows[i]);
		made = 0;
		while (made < RAND_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 2 && long_cols < 2) begin
				len = $urandom_range(257, 280);
				long_cols++;
			end else if (kind < 12) begin
				len = $urandom_range(13, 60);
			end else begin
				len = $urandom_range(1, 12);
			end
			for (int k = 0; k < len; k++) begin
				it.sample_a = pick_sample();
				it.sample_b = pick_sample();
				if (len > 256 || $urandom_range(0, 9) < 8) begin
					it.a_defined = 1'b1;
					it.b_defined = 1'b1;
				end else begin
					it.a_defined = 1'($urandom_range(0, 1));
					it.b_defined = 1'($urandom_range(0, 1));
				end
				it.column_end = (k == len - 1);
				row.item = it;
				row.typed = 1'b0;
				row.res = '0;
				stim_q.insert(stim_q.size(), row);
			end
			made += len;
		end
		total_items = stim_q.size();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (stim_q.size() != 0 || sample_valid)
			@(posedge clk);
		while (cov_expect_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && cov_expect_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
